// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tsa_pkg.sv =====
package tsa_pkg;

    localparam int IDX_W     = 11;
    localparam int DATA_W    = 64;
    localparam int MAP_W     = 64;
    localparam int MAP_BIT_W = 6;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_NO_SLOT = 2'd1;
    localparam logic [1:0] STS_INVALID = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_stat;

endpackage

// ===== src/tsa_in_if.sv =====
interface tsa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [10:0] slot_index;
    logic [63:0] write_value;

    modport source (output valid, output opcode, output slot_index, output write_value,
                    input ready);
    modport sink (input valid, input opcode, input slot_index, input write_value,
                  output ready);
endinterface

// ===== src/tsa_out_if.sv =====
interface tsa_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] granted_index;
    logic [63:0] read_value;
    logic [1:0]  status;

    modport source (output valid, output granted_index, output read_value, output status,
                    input ready);
    modport sink (input valid, input granted_index, input read_value, input status,
                  output ready);
endinterface

// ===== src/tsa_ctrl.sv =====
module tsa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  tsa_pkg::t_stat  i_stat,
    output tsa_pkg::t_cmd   o_cmd,
    output logic            o_in_ready,
    output logic            o_out_valid
);

    tsa_pkg::t_state r_state;
    tsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            tsa_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = tsa_pkg::ST_IDLE;
                end
            end
            tsa_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = tsa_pkg::ST_EXEC;
                end
            end
            tsa_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = tsa_pkg::ST_DONE;
            end
            tsa_pkg::ST_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = tsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tsa_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== src/tsa_datapath.sv =====
module tsa_datapath #(
    parameter int BASE_SLOTS = 64,
    parameter int EXT_SLOTS  = 1024,
    parameter int VALUE_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsa_pkg::t_cmd                 i_cmd,
    output tsa_pkg::t_stat                o_stat,
    input  logic [1:0]                    i_opcode,
    input  logic [tsa_pkg::IDX_W-1:0]     i_slot_index,
    input  logic [tsa_pkg::DATA_W-1:0]    i_write_value,
    output logic [tsa_pkg::IDX_W-1:0]     o_granted_index,
    output logic [tsa_pkg::DATA_W-1:0]    o_read_value,
    output logic [1:0]                    o_status
);

    localparam int W          = tsa_pkg::MAP_W;
    localparam int BIT_W      = tsa_pkg::MAP_BIT_W;
    localparam int BASE_WORDS = (BASE_SLOTS + W - 1) / W;
    localparam int EXT_WORDS  = (EXT_SLOTS + W - 1) / W;
    localparam int ROWS       = BASE_WORDS + EXT_WORDS;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int TOTAL      = BASE_SLOTS + EXT_SLOTS;
    localparam int SLOT_W     = ($clog2(TOTAL + 1) > tsa_pkg::IDX_W) ?
                                $clog2(TOTAL + 1) : tsa_pkg::IDX_W;
    localparam int BW         = (BASE_SLOTS > 1) ? $clog2(BASE_SLOTS) : 1;
    localparam int EW         = (EXT_SLOTS > 1) ? $clog2(EXT_SLOTS) : 1;
    localparam int CLR_A      = (EXT_SLOTS > BASE_SLOTS) ? EXT_SLOTS : BASE_SLOTS;
    localparam int CLR_N      = (CLR_A > ROWS) ? CLR_A : ROWS;
    localparam int CLR_W      = $clog2(CLR_N);

    logic [W-1:0]          r_map [ROWS];
    logic [VALUE_BITS-1:0] r_base_mem [BASE_SLOTS];
    logic [VALUE_BITS-1:0] r_ext_mem [EXT_SLOTS];

    logic [ROWS-1:0]       r_full;
    logic                  r_ext_present;
    logic [CLR_W-1:0]      r_cnt;

    logic [1:0]            r_op;
    logic                  r_in_range;
    logic                  r_is_ext;
    logic [SLOT_W-1:0]     r_local;
    logic [ROW_W-1:0]      r_row;
    logic                  r_any;
    logic [W-1:0]          r_map_rd;
    logic [VALUE_BITS-1:0] r_base_rd;
    logic [VALUE_BITS-1:0] r_ext_rd;

    logic [tsa_pkg::IDX_W-1:0]  r_granted;
    logic [tsa_pkg::DATA_W-1:0] r_rdata;
    logic [1:0]                 r_status;

    logic [SLOT_W-1:0] idx_ext;
    logic              in_range;
    logic              is_ext;
    logic [SLOT_W-1:0] a_local;
    logic [SLOT_W-1:0] a_rowlocal;
    logic [ROW_W-1:0]  a_row;
    logic [ROW_W-1:0]  f_row;
    logic              f_any;
    logic              f_is_ext;
    logic [ROW_W-1:0]  rd_row;

    logic [ROW_W-1:0]  b_rowlocal;
    logic [SLOT_W-1:0] lim;
    logic [W-1:0]      pad;
    logic [W-1:0]      word;
    logic [BIT_W-1:0]  z_pos;
    logic [SLOT_W-1:0] alloc_local;
    logic [SLOT_W-1:0] b_local;
    logic              free_bit;
    logic              do_set;
    logic              do_clr;
    logic [W-1:0]      set_word;

    logic                  map_we;
    logic [ROW_W-1:0]      map_waddr;
    logic [W-1:0]          map_wdata;
    logic                  base_we;
    logic [BW-1:0]         base_waddr;
    logic [VALUE_BITS-1:0] base_wdata;
    logic                  ext_we;
    logic [EW-1:0]         ext_waddr;
    logic [VALUE_BITS-1:0] ext_wdata;
    logic                  clr_row;
    logic                  clr_base;
    logic                  clr_ext;

    assign idx_ext    = SLOT_W'(i_slot_index);
    assign in_range   = idx_ext < SLOT_W'(TOTAL);
    assign is_ext     = idx_ext >= SLOT_W'(BASE_SLOTS);
    assign a_local    = is_ext ? (idx_ext - SLOT_W'(BASE_SLOTS)) : idx_ext;
    assign a_rowlocal = a_local >> BIT_W;
    assign a_row      = is_ext ? ROW_W'(a_rowlocal + SLOT_W'(BASE_WORDS)) : ROW_W'(a_rowlocal);

    always_comb begin
        f_row = '0;
        f_any = 1'b0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                f_row = ROW_W'(i);
                f_any = 1'b1;
            end
        end
    end

    assign f_is_ext = f_row >= ROW_W'(BASE_WORDS);
    assign rd_row   = (i_opcode == tsa_pkg::OP_ALLOC) ? f_row : a_row;

    assign b_rowlocal = r_is_ext ? (r_row - ROW_W'(BASE_WORDS)) : r_row;
    assign lim = (r_is_ext ? SLOT_W'(EXT_SLOTS) : SLOT_W'(BASE_SLOTS))
               - (SLOT_W'(b_rowlocal) << BIT_W);

    always_comb begin
        for (int b = 0; b < W; b++) begin
            pad[b] = SLOT_W'(b) >= lim;
        end
    end

    assign word = r_map_rd | pad;

    always_comb begin
        z_pos = '0;
        for (int b = W - 1; b >= 0; b--) begin
            if (!word[b]) begin
                z_pos = BIT_W'(b);
            end
        end
    end

    assign alloc_local = (SLOT_W'(b_rowlocal) << BIT_W) | SLOT_W'(z_pos);
    assign b_local     = (r_op == tsa_pkg::OP_ALLOC) ? alloc_local : r_local;
    assign free_bit    = r_map_rd[r_local[BIT_W-1:0]];
    assign set_word    = r_map_rd | (W'(1) << z_pos);
    assign do_set      = i_cmd.exec && (r_op == tsa_pkg::OP_ALLOC) && r_any;
    assign do_clr      = i_cmd.exec && (r_op == tsa_pkg::OP_FREE) && r_in_range && free_bit;

    assign clr_row  = i_cmd.clr_step && ({1'b0, r_cnt} < (CLR_W + 1)'(ROWS));
    assign clr_base = i_cmd.clr_step && ({1'b0, r_cnt} < (CLR_W + 1)'(BASE_SLOTS));
    assign clr_ext  = i_cmd.clr_step && ({1'b0, r_cnt} < (CLR_W + 1)'(EXT_SLOTS));

    always_comb begin
        map_we     = 1'b0;
        map_waddr  = r_row;
        map_wdata  = '0;
        base_we    = 1'b0;
        base_waddr = b_local[BW-1:0];
        base_wdata = '0;
        ext_we     = 1'b0;
        ext_waddr  = b_local[EW-1:0];
        ext_wdata  = '0;
        if (i_cmd.clr_step) begin
            map_we     = clr_row;
            map_waddr  = ROW_W'(r_cnt);
            base_we    = clr_base;
            base_waddr = BW'(r_cnt);
            ext_we     = clr_ext;
            ext_waddr  = EW'(r_cnt);
        end else if (i_cmd.accept) begin
            if ((i_opcode == tsa_pkg::OP_WRITE) && in_range) begin
                base_we    = !is_ext;
                ext_we     = is_ext;
                base_waddr = a_local[BW-1:0];
                ext_waddr  = a_local[EW-1:0];
                base_wdata = i_write_value[VALUE_BITS-1:0];
                ext_wdata  = i_write_value[VALUE_BITS-1:0];
            end
        end else if (do_set || do_clr) begin
            map_we    = 1'b1;
            map_wdata = do_set ? set_word : (r_map_rd & ~(W'(1) << r_local[BIT_W-1:0]));
            base_we   = !r_is_ext;
            ext_we    = r_is_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_waddr] <= map_wdata;
        end
        if (i_cmd.accept) begin
            r_map_rd <= r_map[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (base_we) begin
            r_base_mem[base_waddr] <= base_wdata;
        end
        if (i_cmd.accept) begin
            r_base_rd <= r_base_mem[a_local[BW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ext_we) begin
            r_ext_mem[ext_waddr] <= ext_wdata;
        end
        if (i_cmd.accept) begin
            r_ext_rd <= r_ext_mem[a_local[EW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= '0;
            r_full        <= '0;
            r_ext_present <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_cnt <= r_cnt + CLR_W'(1);
            end
            if (i_cmd.accept && (i_opcode == tsa_pkg::OP_WRITE) && in_range && is_ext) begin
                r_ext_present <= 1'b1;
            end
            if (do_set) begin
                r_full[r_row] <= &(set_word | pad);
                if (r_is_ext) begin
                    r_ext_present <= 1'b1;
                end
            end
            if (do_clr) begin
                r_full[r_row] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= i_opcode;
            r_in_range <= in_range;
            r_local    <= a_local;
            r_any      <= f_any;
            r_row      <= rd_row;
            r_is_ext   <= (i_opcode == tsa_pkg::OP_ALLOC) ? f_is_ext : is_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_granted <= '0;
            r_rdata   <= '0;
            r_status  <= tsa_pkg::STS_OK;
            case (r_op)
                tsa_pkg::OP_ALLOC: begin
                    if (r_any) begin
                        r_granted <= r_is_ext ?
                            tsa_pkg::IDX_W'(alloc_local + SLOT_W'(BASE_SLOTS)) :
                            tsa_pkg::IDX_W'(alloc_local);
                    end else begin
                        r_status <= tsa_pkg::STS_NO_SLOT;
                    end
                end
                tsa_pkg::OP_FREE: begin
                    if (!r_in_range || !free_bit) begin
                        r_status <= tsa_pkg::STS_INVALID;
                    end
                end
                tsa_pkg::OP_READ: begin
                    if (!r_in_range) begin
                        r_status <= tsa_pkg::STS_INVALID;
                    end else if (r_is_ext) begin
                        r_rdata <= r_ext_present ? tsa_pkg::DATA_W'(r_ext_rd) : '0;
                    end else begin
                        r_rdata <= tsa_pkg::DATA_W'(r_base_rd);
                    end
                end
                default: begin
                    if (!r_in_range) begin
                        r_status <= tsa_pkg::STS_INVALID;
                    end
                end
            endcase
        end
    end

    assign o_stat.clr_last = r_cnt == CLR_W'(CLR_N - 1);
    assign o_granted_index = r_granted;
    assign o_read_value    = r_rdata;
    assign o_status        = r_status;

endmodule

// ===== src/two_region_slot_allocator_unit.sv =====
// Each accepted request word is executed in the following state; its result word
// is registered there and held valid until it is taken. The controller handles one
// request at a time through one registered bitmap read.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every bitmap
// row and both value memories before the first request word is accepted.
`include "assert_macros.svh"

module two_region_slot_allocator_unit #(
    parameter int BASE_SLOTS = 64,
    parameter int EXT_SLOTS  = 1024,
    parameter int VALUE_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsa_in_if.sink     i_in,
    tsa_out_if.source  o_out
);

    tsa_pkg::t_cmd  s_cmd;
    tsa_pkg::t_stat s_stat;

    tsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (s_stat),
        .o_cmd       (s_cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    tsa_datapath #(
        .BASE_SLOTS (BASE_SLOTS),
        .EXT_SLOTS  (EXT_SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .o_stat          (s_stat),
        .i_opcode        (i_in.opcode),
        .i_slot_index    (i_in.slot_index),
        .i_write_value   (i_in.write_value),
        .o_granted_index (o_out.granted_index),
        .o_read_value    (o_out.read_value),
        .o_status        (o_out.status)
    );

    `TSA_ASSERT_IMP(a_ready_excl, i_clk, i_rst_n, i_in.ready, !o_out.valid, "ready while result pending")
    `TSA_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, i_in.valid && i_in.ready, s_cmd.exec, "no execute after accept")
    `TSA_ASSERT_NXT(a_exec_done, i_clk, i_rst_n, s_cmd.exec, o_out.valid, "no result after execute")
    `TSA_ASSERT_IMP(a_fail_index, i_clk, i_rst_n, o_out.valid && (o_out.status != tsa_pkg::STS_OK), o_out.granted_index == '0, "index on failure")

endmodule
